// ===== rtl/core/lnf_pkg.sv =====
package lnf_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int COUNT_W      = 7;
  localparam int EPS_W        = 16;
  localparam int DATA_W       = 16;
  localparam int CH_W         = 6;
  localparam int VAR_W        = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int DIV_N        = 64;
  localparam int DIV_D        = 33;
  localparam int ROOT_W       = 64;
  localparam int INV_W        = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EPSILON       = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd1;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_INV,
    DIV_NORM
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_INV_GO,
    ST_INV_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_READ,
    ST_CENT,
    ST_MUL,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    prod;
    logic    div_start;
    div_op_t div_op;
    logic    div_take;
    logic    sqrt_start;
    logic    sqrt_take;
    logic    ch_clear;
    logic    ch_next;
    logic    cent;
    logic    mul;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic last_load;
    logic div_done;
    logic sqrt_done;
    logic ch_last;
  } stat_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lnf_ram.sv =====
module lnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lnf_div.sv =====
module lnf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lnf_pkg::DIV_N-1:0]  dividend,
  input  logic [lnf_pkg::DIV_D-1:0]  divisor,
  output logic [lnf_pkg::DIV_N-1:0]  quotient,
  output logic                       done
);

  localparam int N = lnf_pkg::DIV_N;
  localparam int D = lnf_pkg::DIV_D;
  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem;
  logic [D-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          run;
  logic [D:0]    trial;
  logic          fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quotient[N-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(N);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (run) begin
      if (fits) begin
        rem      <= D'(trial - {1'b0, dsr});
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem      <= trial[D-1:0];
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/lnf_isqrt.sv =====
module lnf_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lnf_pkg::ROOT_W-1:0]  radicand,
  output logic [lnf_pkg::INV_W-1:0]   root,
  output logic                        done
);

  localparam int W  = lnf_pkg::ROOT_W;
  localparam int CW = $clog2(W / 2 + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  res;
  logic [W-1:0]  bitv;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W-1:0]  trial;

  assign trial = res + bitv;
  assign root  = res[lnf_pkg::INV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W / 2);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Digit-by-digit root; starting at the top bit costs nothing in accuracy.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= {2'b01, {(W-2){1'b0}}};
    end else if (run) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== rtl/core/lnf_ctrl.sv =====
module lnf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lnf_pkg::stat_t  stat,
  output lnf_pkg::cmd_t   cmd,
  output logic            busy
);

  lnf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lnf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lnf_pkg::ST_IDLE:      if (start && stat.last_load) state_next = lnf_pkg::ST_PROD;
      lnf_pkg::ST_PROD:      state_next = lnf_pkg::ST_MEAN_GO;
      lnf_pkg::ST_MEAN_GO:   state_next = lnf_pkg::ST_MEAN_WAIT;
      lnf_pkg::ST_MEAN_WAIT: if (stat.div_done) state_next = lnf_pkg::ST_VAR_GO;
      lnf_pkg::ST_VAR_GO:    state_next = lnf_pkg::ST_VAR_WAIT;
      lnf_pkg::ST_VAR_WAIT:  if (stat.div_done) state_next = lnf_pkg::ST_INV_GO;
      lnf_pkg::ST_INV_GO:    state_next = lnf_pkg::ST_INV_WAIT;
      lnf_pkg::ST_INV_WAIT:  if (stat.div_done) state_next = lnf_pkg::ST_SQRT_GO;
      lnf_pkg::ST_SQRT_GO:   state_next = lnf_pkg::ST_SQRT_WAIT;
      lnf_pkg::ST_SQRT_WAIT: if (stat.sqrt_done) state_next = lnf_pkg::ST_READ;
      lnf_pkg::ST_READ:      state_next = lnf_pkg::ST_CENT;
      lnf_pkg::ST_CENT:      state_next = lnf_pkg::ST_MUL;
      lnf_pkg::ST_MUL:       state_next = lnf_pkg::ST_NORM_GO;
      lnf_pkg::ST_NORM_GO:   state_next = lnf_pkg::ST_NORM_WAIT;
      lnf_pkg::ST_NORM_WAIT: if (stat.div_done) state_next = lnf_pkg::ST_EMIT;
      lnf_pkg::ST_EMIT: begin
        state_next = stat.ch_last ? lnf_pkg::ST_IDLE : lnf_pkg::ST_READ;
      end
      default:               state_next = lnf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = lnf_pkg::DIV_MEAN;
    busy       = 1'b1;
    unique case (state)
      lnf_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      lnf_pkg::ST_PROD:      cmd.prod = 1'b1;
      lnf_pkg::ST_MEAN_GO:   cmd.div_start = 1'b1;
      lnf_pkg::ST_MEAN_WAIT: cmd.div_take = stat.div_done;
      lnf_pkg::ST_VAR_GO: begin
        cmd.div_op    = lnf_pkg::DIV_VAR;
        cmd.div_start = 1'b1;
      end
      lnf_pkg::ST_VAR_WAIT: begin
        cmd.div_op   = lnf_pkg::DIV_VAR;
        cmd.div_take = stat.div_done;
      end
      lnf_pkg::ST_INV_GO: begin
        cmd.div_op    = lnf_pkg::DIV_INV;
        cmd.div_start = 1'b1;
      end
      lnf_pkg::ST_INV_WAIT: begin
        cmd.div_op   = lnf_pkg::DIV_INV;
        cmd.div_take = stat.div_done;
      end
      lnf_pkg::ST_SQRT_GO:   cmd.sqrt_start = 1'b1;
      lnf_pkg::ST_SQRT_WAIT: begin
        cmd.sqrt_take = stat.sqrt_done;
        cmd.ch_clear  = stat.sqrt_done;
      end
      lnf_pkg::ST_READ:      cmd.div_op = lnf_pkg::DIV_NORM;
      lnf_pkg::ST_CENT:      cmd.cent = 1'b1;
      lnf_pkg::ST_MUL:       cmd.mul = 1'b1;
      lnf_pkg::ST_NORM_GO: begin
        cmd.div_op    = lnf_pkg::DIV_NORM;
        cmd.div_start = 1'b1;
      end
      lnf_pkg::ST_NORM_WAIT: begin
        cmd.div_op   = lnf_pkg::DIV_NORM;
        cmd.div_take = stat.div_done;
      end
      lnf_pkg::ST_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.ch_next = !stat.ch_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/lnf_dp.sv =====
module lnf_dp #(
  parameter int MAX_CHANNELS = lnf_pkg::MAX_CHANNELS,
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lnf_pkg::cmd_t                         cmd,
  output lnf_pkg::stat_t                        stat,
  input  logic signed [lnf_pkg::DATA_W-1:0]     sample,
  input  logic signed [lnf_pkg::DATA_W-1:0]     gain,
  input  logic signed [lnf_pkg::DATA_W-1:0]     offset,
  input  logic                                  cfg_write,
  input  logic [lnf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lnf_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  strobe,
  output logic [lnf_pkg::CH_W-1:0]              channel_index,
  output logic signed [lnf_pkg::DATA_W-1:0]     normalized_value,
  output logic signed [lnf_pkg::DATA_W-1:0]     result_value,
  output logic signed [lnf_pkg::DATA_W-1:0]     token_mean,
  output logic [lnf_pkg::VAR_W-1:0]             token_variance,
  output logic                                  last_of_token
);

  localparam int CW  = lnf_pkg::COUNT_W;
  localparam int DW  = lnf_pkg::DATA_W;
  localparam int S1W = 24;
  localparam int S2W = 37;
  localparam int PAW = 44;
  localparam int PBW = 48;
  localparam int CEW = 24;
  localparam int PRW = 57;
  localparam int N   = lnf_pkg::DIV_N;
  localparam int D   = lnf_pkg::DIV_D;

  logic [CW-1:0]            channel_count;
  logic [lnf_pkg::EPS_W-1:0] epsilon;
  logic [CW-1:0]            n;
  logic [CW-1:0]            loaded;
  logic [CW-1:0]            slot;
  logic                     restart;
  logic signed [S1W-1:0]    s1;
  logic [S2W-1:0]           s2;
  logic signed [31:0]       sq;
  logic [PAW-1:0]           pa;
  logic signed [PBW-1:0]    pb;
  logic signed [PBW-1:0]    num;
  logic signed [PBW-1:0]    num_c;
  logic [13:0]              nsq;
  logic [lnf_pkg::EPS_W-1:0] eps_eff;
  logic signed [DW-1:0]     mean;
  logic [lnf_pkg::VAR_W-1:0] var_r;
  logic [N-1:0]             recip;
  logic [lnf_pkg::INV_W-1:0] inv;
  logic [AW-1:0]            ch;
  logic [3*DW-1:0]          rdata;
  logic signed [DW-1:0]     x_rd;
  logic signed [CEW-1:0]    cent;
  logic signed [PRW-1:0]    prod;
  logic signed [DW-1:0]     gain_r;
  logic signed [DW-1:0]     offset_r;
  logic signed [DW-1:0]     nv;
  logic signed [N-1:0]      sa;
  logic [D-1:0]             dsr;
  logic                     sa_neg;
  logic                     div_neg;
  logic [N-1:0]             quot;
  logic signed [N-1:0]      qs;
  logic [lnf_pkg::INV_W-1:0] root;
  logic signed [31:0]       gp;
  logic signed [33:0]       rsum;

  always_comb begin
    if (channel_count == '0) begin
      n = CW'(1);
    end else if (channel_count > CW'(MAX_CHANNELS)) begin
      n = CW'(MAX_CHANNELS);
    end else begin
      n = channel_count;
    end
  end

  assign restart        = loaded >= n;
  assign slot           = restart ? '0 : loaded;
  assign stat.last_load = (slot + 1'b1) == n;
  assign stat.ch_last   = (CW'(ch) + 1'b1) == n;
  assign sq             = sample * sample;
  assign eps_eff        = (epsilon == '0) ? lnf_pkg::EPS_W'(1) : epsilon;
  assign nsq            = 14'(n) * 14'(n);
  assign num            = $signed({4'b0, pa}) - pb;
  assign num_c          = num[PBW-1] ? '0 : num;
  assign x_rd           = rdata[3*DW-1:2*DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= lnf_pkg::COUNT_RESET;
      epsilon       <= lnf_pkg::EPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lnf_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[CW-1:0];
        lnf_pkg::CFG_EPSILON:       epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  // A new channel count drops any partly loaded token.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      s1     <= '0;
      s2     <= '0;
    end else if (cfg_write && cfg_index == lnf_pkg::CFG_CHANNEL_COUNT) begin
      loaded <= '0;
      s1     <= '0;
      s2     <= '0;
    end else if (cmd.load) begin
      loaded <= slot + 1'b1;
      s1     <= (restart ? '0 : s1) + S1W'(sample);
      s2     <= (restart ? '0 : s2) + S2W'(unsigned'(sq));
    end
  end

  lnf_ram #(
    .WIDTH(3 * DW),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(slot[AW-1:0]),
    .wdata({sample, gain, offset}),
    .raddr(ch),
    .rdata(rdata)
  );

  // Floor division of a signed value uses ~a / d = ~(a / d) for negative a.
  always_comb begin
    unique case (cmd.div_op)
      lnf_pkg::DIV_MEAN: begin
        sa  = (N'(s1) <<< 1) + $signed(N'(n));
        dsr = D'({n, 1'b0});
      end
      lnf_pkg::DIV_VAR: begin
        sa  = (N'(num_c) <<< 1) + $signed(N'(nsq));
        dsr = D'({nsq, 1'b0});
      end
      lnf_pkg::DIV_INV: begin
        sa  = $signed({2'b01, {(N-2){1'b0}}});
        dsr = D'(var_r) + D'(eps_eff);
      end
      lnf_pkg::DIV_NORM: begin
        sa  = (N'(prod) <<< 1) + $signed(N'({n, 19'b0}));
        dsr = D'({n, 20'b0});
      end
      default: begin
        sa  = '0;
        dsr = D'(1);
      end
    endcase
  end

  assign sa_neg = sa[N-1];

  lnf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(sa_neg ? ~sa : sa),
    .divisor (dsr),
    .quotient(quot),
    .done    (stat.div_done)
  );

  assign qs = div_neg ? $signed(~quot) : $signed(quot);

  lnf_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .radicand(recip),
    .root    (root),
    .done    (stat.sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= sa_neg;
    end
    if (cmd.prod) begin
      pa <= PAW'(n) * PAW'(s2);
      pb <= PBW'(s1) * PBW'(s1);
    end
    if (cmd.div_take) begin
      unique case (cmd.div_op)
        lnf_pkg::DIV_MEAN: mean <= lnf_pkg::sat16(qs);
        lnf_pkg::DIV_VAR: begin
          var_r <= (qs[N-1:lnf_pkg::VAR_W] != '0) ? '1 : qs[lnf_pkg::VAR_W-1:0];
        end
        lnf_pkg::DIV_INV:  recip <= quot;
        lnf_pkg::DIV_NORM: nv <= lnf_pkg::sat16(qs);
        default: ;
      endcase
    end
    if (cmd.sqrt_take) begin
      inv <= root;
    end
    if (cmd.cent) begin
      cent     <= CEW'($signed({1'b0, n}) * x_rd) - s1;
      gain_r   <= rdata[2*DW-1:DW];
      offset_r <= rdata[DW-1:0];
    end
    if (cmd.mul) begin
      prod <= PRW'(cent) * PRW'($signed({1'b0, inv}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.ch_clear) begin
      ch <= '0;
    end else if (cmd.ch_next) begin
      ch <= ch + 1'b1;
    end
  end

  assign gp   = gain_r * nv;
  assign rsum = ((34'(gp) + 34'sd32768) >>> 16) + 34'(offset_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      channel_index    <= lnf_pkg::CH_W'(ch);
      normalized_value <= nv;
      result_value     <= lnf_pkg::sat16(64'(rsum));
      token_mean       <= mean;
      token_variance   <= var_r;
      last_of_token    <= stat.ch_last;
    end
  end

endmodule

// ===== rtl/core/layer_norm_forward.sv =====
// Channel     Ports                                         Flow
// input       start, busy, sample, gain, offset             taken when start & !busy
// config      cfg_write, cfg_index, cfg_data                taken when cfg_write
// result      strobe, channel_index, normalized_value,      one cycle per word,
//             result_value, token_mean, token_variance,     no back-pressure
//             last_of_token
//
// Samples load at one word per cycle while busy is low; busy rises after the
// last channel of a token. The token then passes through the shared serial
// divider (mean, variance, reciprocal) and the bit-serial square root, and each
// channel then takes one 64-step division for its normalized value.
// Reset (rst, synchronous) returns the controller to idle and the config registers
// to their defaults; the receiver cannot stall, so each result word shows once.
module layer_norm_forward #(
  parameter int MAX_CHANNELS = lnf_pkg::MAX_CHANNELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [lnf_pkg::DATA_W-1:0]  sample,
  input  logic signed [lnf_pkg::DATA_W-1:0]  gain,
  input  logic signed [lnf_pkg::DATA_W-1:0]  offset,
  input  logic                               cfg_write,
  input  logic [lnf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lnf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               strobe,
  output logic [lnf_pkg::CH_W-1:0]           channel_index,
  output logic signed [lnf_pkg::DATA_W-1:0]  normalized_value,
  output logic signed [lnf_pkg::DATA_W-1:0]  result_value,
  output logic signed [lnf_pkg::DATA_W-1:0]  token_mean,
  output logic [lnf_pkg::VAR_W-1:0]          token_variance,
  output logic                               last_of_token
);

  lnf_pkg::cmd_t  cmd;
  lnf_pkg::stat_t stat;

  lnf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  lnf_dp #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .sample          (sample),
    .gain            (gain),
    .offset          (offset),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .strobe          (strobe),
    .channel_index   (channel_index),
    .normalized_value(normalized_value),
    .result_value    (result_value),
    .token_mean      (token_mean),
    .token_variance  (token_variance),
    .last_of_token   (last_of_token)
  );

endmodule

// ===== dv/layer_norm_forward_test.sv =====
`timescale 1ns / 100ps

module layer_norm_forward_test;
  import lnf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] nv;
    logic signed [DATA_W-1:0] rv;
    logic signed [DATA_W-1:0] mean;
    logic [VAR_W-1:0]         vq;
    logic                     last;
  } norm_word_t;

  typedef struct {
    int     set_count;
    int     set_eps;
    int     x;
    int     g;
    int     o;
    bit     typed;
    int     e_nv;
    int     e_rv;
    int     e_mean;
    longint e_var;
  } stim_row_t;

  logic clk, rst, start, busy, cfg_write, strobe, last_of_token;
  logic signed [DATA_W-1:0] sample, gain, offset;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [CH_W-1:0] channel_index;
  logic signed [DATA_W-1:0] normalized_value, result_value, token_mean;
  logic [VAR_W-1:0] token_variance;

  layer_norm_forward dut (.*);

  // Shadow of the block's state.
  logic [COUNT_W-1:0] shadow_count;
  logic [EPS_W-1:0] shadow_eps;
  logic signed [DATA_W-1:0] x_buf [MAX_CHANNELS];
  logic signed [DATA_W-1:0] g_buf [MAX_CHANNELS];
  logic signed [DATA_W-1:0] o_buf [MAX_CHANNELS];
  longint token_sum;
  int loaded;

  norm_word_t pending_words [$];
  int fails = 0;
  int sent = 0;
  longint cycles = 0;

  stim_row_t rows [16];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic longint floor_div(input longint a, input longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Loads one word into the shadow and, on the token's last channel, queues all
  // of the token's normalized words when queue_it is set.
  task automatic normalize_word(input logic signed [DATA_W-1:0] x, g, o, input bit queue_it);
    int n, slot;
    longint s1, s2, nn, mean, num, cen, den, nv, rv;
    longint unsigned vq, d, inv;
    norm_word_t w;
    n = shadow_count == 0 ? 1 : (shadow_count > MAX_CHANNELS ? MAX_CHANNELS : shadow_count);
    slot = loaded;
    if (slot >= n) begin
      slot = 0;
      token_sum = 0;
    end
    x_buf[slot] = x;
    g_buf[slot] = g;
    o_buf[slot] = o;
    token_sum += x;
    loaded = slot + 1;
    if (loaded < n) return;
    s1 = token_sum;
    s2 = 0;
    for (int c = 0; c < n; c++) s2 += longint'(x_buf[c]) * longint'(x_buf[c]);
    nn = n;
    mean = floor_div(2 * s1 + nn, 2 * nn);
    num = nn * s2 - s1 * s1;
    if (num < 0) num = 0;
    vq = (longint'(num) * 2 + nn * nn) / (2 * nn * nn);
    if (vq > 64'hFFFF_FFFF) vq = 64'hFFFF_FFFF;
    d = vq + (shadow_eps == 0 ? 1 : shadow_eps);
    inv = int_sqrt((64'd1 << 62) / d);
    den = nn << 19;
    for (int c = 0; c < n; c++) begin
      cen = nn * x_buf[c] - s1;
      nv = clamp16(floor_div(2 * cen * longint'(inv) + den, 2 * den));
      rv = clamp16(floor_div(longint'(g_buf[c]) * nv + 32768, 65536) + o_buf[c]);
      w.ch = CH_W'(c);
      w.nv = DATA_W'(nv);
      w.rv = DATA_W'(rv);
      w.mean = DATA_W'(clamp16(mean));
      w.vq = VAR_W'(vq);
      w.last = (c + 1 == n);
      if (queue_it) pending_words.push_back(w);
    end
    loaded = 0;
    token_sum = 0;
  endtask

  always @(negedge clk) begin
    norm_word_t w;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: channel_index %0d", channel_index);
        fails++;
      end else begin
        w = pending_words.pop_front();
        if (channel_index !== w.ch) begin
          $error("channel_index exp %0d got %0d", w.ch, channel_index);
          fails++;
        end
        if (normalized_value !== w.nv) begin
          $error("normalized_value exp %0d got %0d", w.nv, normalized_value);
          fails++;
        end
        if (result_value !== w.rv) begin
          $error("result_value exp %0d got %0d", w.rv, result_value);
          fails++;
        end
        if (token_mean !== w.mean) begin
          $error("token_mean exp %0d got %0d", w.mean, token_mean);
          fails++;
        end
        if (token_variance !== w.vq) begin
          $error("token_variance exp %0d got %0d", w.vq, token_variance);
          fails++;
        end
        if (last_of_token !== w.last) begin
          $error("last_of_token exp %0d got %0d", w.last, last_of_token);
          fails++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge that took the word.
  task automatic send_word(input logic signed [DATA_W-1:0] x, g, o, input bit queue_it);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sample <= x;
    gain <= g;
    offset <= o;
    do @(negedge clk); while (busy);
    @(posedge clk);
    normalize_word(x, g, o, queue_it);
    sent++;
  endtask

  // Holds off until every queued word has come out and the block is quiet.
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // The enable drops for a cycle after each write so that back-to-back writes
  // never drive it twice in one step.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CHANNEL_COUNT) begin
      shadow_count = val[COUNT_W-1:0];
      loaded = 0;
      token_sum = 0;
    end else begin
      shadow_eps = val;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] rand_sample(input int mode, input int base);
    case (mode)
      0: return DATA_W'($urandom());
      1: return DATA_W'(base + int'($urandom_range(0, 64)) - 32);
      2: return DATA_W'(base);
      default: return DATA_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  initial begin
    norm_word_t w;
    int n, tokens, mode, base, pick, k;
    rows = '{
      '{1, 1, 0, 0, 0, 1, 0, 0, 0, 0},
      '{-1, -1, 32767, -32768, 32767, 1, 0, 32767, 32767, 0},
      '{-1, -1, -32768, 32767, -32768, 1, 0, -32768, -32768, 0},
      '{0, -1, 100, 4096, -5, 1, 0, -5, 100, 0},
      '{2, -1, 256, 32767, 32767, 0, 0, 0, 0, 0},
      '{-1, -1, -256, 32767, -32768, 0, 0, 0, 0, 0},
      '{-1, 65535, 32767, 32767, 32767, 0, 0, 0, 0, 0},
      '{-1, -1, -32768, -32768, -32768, 0, 0, 0, 0, 0},
      '{3, 1, 10, 4096, 0, 0, 0, 0, 0, 0},
      '{-1, -1, 20, 4096, 0, 0, 0, 0, 0, 0},
      // Count rewritten with two channels loaded: the partial token is dropped.
      '{3, -1, -300, -4096, 100, 0, 0, 0, 0, 0},
      '{-1, -1, 500, 12000, -100, 0, 0, 0, 0, 0},
      // Epsilon changed inside a token takes effect at the token's end.
      '{-1, 40000, 700, -20000, 5, 0, 0, 0, 0, 0},
      '{2, 1, 5, 4096, 0, 0, 0, 0, 0, 0},
      '{-1, -1, 5, 4096, 0, 0, 0, 0, 0, 0},
      '{-1, -1, 1, 1, 1, 0, 0, 0, 0, 0}
    };
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample = '0;
    gain = '0;
    offset = '0;
    shadow_count = COUNT_RESET;
    shadow_eps = EPS_RESET;
    loaded = 0;
    token_sum = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_count >= 0 || rows[i].set_eps >= 0) drain();
      if (rows[i].set_count >= 0)
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(rows[i].set_count));
      if (rows[i].set_eps >= 0) write_reg(CFG_EPSILON, CFG_DATA_W'(rows[i].set_eps));
      if (rows[i].typed) begin
        w.ch = '0;
        w.nv = DATA_W'(rows[i].e_nv);
        w.rv = DATA_W'(rows[i].e_rv);
        w.mean = DATA_W'(rows[i].e_mean);
        w.vq = VAR_W'(rows[i].e_var);
        w.last = 1'b1;
        pending_words.push_back(w);
      end
      send_word(DATA_W'(rows[i].x), DATA_W'(rows[i].g), DATA_W'(rows[i].o), !rows[i].typed);
    end

    while (sent < 300) begin
      drain();
      pick = $urandom_range(0, 19);
      if (pick == 0) n = 64;
      else if (pick == 1) n = $urandom_range(65, 127);
      else if (pick == 2) n = 0;
      else n = $urandom_range(1, 8);
      // Upper data bits of the count register are don't-care.
      write_reg(CFG_CHANNEL_COUNT,
                {(CFG_DATA_W - COUNT_W)'($urandom_range(0, 511)), n[COUNT_W-1:0]});
      case ($urandom_range(0, 3))
        0: write_reg(CFG_EPSILON, CFG_DATA_W'(1));
        1: write_reg(CFG_EPSILON, CFG_DATA_W'(65535));
        2: write_reg(CFG_EPSILON, CFG_DATA_W'($urandom()));
        default: ;
      endcase
      if (n == 0) n = 1;
      if (n > MAX_CHANNELS) n = MAX_CHANNELS;
      tokens = n >= 32 ? 1 : $urandom_range(1, 4);
      for (int t = 0; t < tokens; t++) begin
        mode = $urandom_range(0, 3);
        base = int'($urandom_range(0, 65535)) - 32768;
        if (base > 32700) base = 32700;
        for (int c = 0; c < n; c++)
          send_word(rand_sample(mode, base), DATA_W'($urandom()), DATA_W'($urandom()), 1'b1);
      end
      // Occasionally leave a broken token behind for the next count write to drop.
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, n - 1);
        for (int c = 0; c < k; c++)
          send_word(DATA_W'($urandom()), DATA_W'($urandom()), DATA_W'($urandom()), 1'b1);
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lnf_pkg.sv
rtl/core/lnf_ram.sv
rtl/core/lnf_div.sv
rtl/core/lnf_isqrt.sv
rtl/core/lnf_ctrl.sv
rtl/core/lnf_dp.sv
rtl/core/layer_norm_forward.sv
dv/layer_norm_forward_test.sv
